>>> hdl/ppoc_pkg.sv
package ppoc_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam logic [2:0] VERDICT_UNSURE = 3'd0;
	localparam logic [2:0] VERDICT_STACK = 3'd1;
	localparam logic [2:0] VERDICT_QUEUE = 3'd2;
	localparam logic [2:0] VERDICT_PRIO = 3'd3;
	localparam logic [2:0] VERDICT_NONE = 3'd4;

	localparam int FLAG_STACK_BIT = 0;
	localparam int FLAG_QUEUE_BIT = 1;
	localparam int FLAG_PRIO_BIT = 2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POP_RD,
		ST_POP_CMP,
		ST_POP_LAST,
		ST_DN_RD,
		ST_DN_CMP,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DONE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic do_push;
		logic pop_rd;
		logic pop_cmp;
		logic pop_last;
		logic dn_rd;
		logic dn_cmp;
		logic up_rd;
		logic up_cmp;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic heap_empty;
		logic up_done;
		logic dn_done;
		logic last;
		logic push;
	} status_t;

endpackage

>>> hdl/ppoc_ram.sv
module ppoc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hdl/ppoc_ctrl.sv
module ppoc_ctrl
	import ppoc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_fire,
	input  logic    out_free,
	input  status_t st,
	output cmd_t    cmd,
	output logic    busy
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = ST_POP_RD;
				end
			end
			ST_POP_RD: begin
				if (st.push) begin
					if (st.full) begin
						state_d = ST_DONE;
					end else begin
						cmd.do_push = 1'b1;
						state_d = ST_UP_RD;
					end
				end else begin
					cmd.pop_rd = 1'b1;
					state_d = ST_POP_CMP;
				end
			end
			ST_POP_CMP: begin
				cmd.pop_cmp = 1'b1;
				state_d = st.heap_empty ? ST_DONE : ST_POP_LAST;
			end
			ST_POP_LAST: begin
				cmd.pop_last = 1'b1;
				state_d = ST_DN_RD;
			end
			ST_DN_RD: begin
				if (st.dn_done) begin
					state_d = ST_DONE;
				end else begin
					cmd.dn_rd = 1'b1;
					state_d = ST_DN_CMP;
				end
			end
			ST_DN_CMP: begin
				cmd.dn_cmp = 1'b1;
				state_d = ST_DN_RD;
			end
			ST_UP_RD: begin
				if (st.up_done) begin
					state_d = ST_DONE;
				end else begin
					cmd.up_rd = 1'b1;
					state_d = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				cmd.up_cmp = 1'b1;
				state_d = ST_UP_RD;
			end
			ST_DONE: begin
				if (!st.last) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

>>> hdl/ppoc_dp.sv
module ppoc_dp
	import ppoc_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        opcode,
	input  logic [31:0] value,
	input  logic        end_of_trace,
	output status_t     st,
	output logic [2:0]  verdict,
	output logic        overflowed
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic signed [VALUE_WIDTH-1:0] val_q;
	logic push_q, last_q;
	logic [AW-1:0] fhead_q;
	logic [CW-1:0] count_q;
	logic [2:0] flags_q;
	logic ovf_q;

	logic [AW-1:0] idx_q, chl_q;
	logic signed [VALUE_WIDTH-1:0] cur_q;
	logic rd_kid_q;

	logic signed [VALUE_WIDTH-1:0] f_rd, l_rd, h_rd, h_rd2;
	logic f_we, l_we, h_we, h2_we;
	logic [AW-1:0] f_wa, l_wa, h_wa, h2_wa, f_ra, l_ra, h_ra, h_ra2;
	logic signed [VALUE_WIDTH-1:0] h_wd, h2_wd;

	logic signed [VALUE_WIDTH-1:0] vn;
	assign vn = VALUE_WIDTH'($signed(value));

	logic [CW:0] tail_w;
	assign tail_w = (CW+1)'(fhead_q) + (CW+1)'(count_q);
	assign f_wa = (tail_w >= (CW+1)'(DEPTH)) ? AW'(tail_w - (CW+1)'(DEPTH)) : AW'(tail_w);
	assign l_wa = AW'(count_q);

	logic [AW:0] l_full, r_full;
	assign l_full = {idx_q, 1'b1};
	assign r_full = (AW+1)'({idx_q, 1'b1}) + 1'b1;
	logic l_in, r_in;
	assign l_in = (CW+1)'(l_full) < (CW+1)'(count_q);
	assign r_in = (CW+1)'(r_full) < (CW+1)'(count_q);

	assign st.full = (count_q >= DEPTH_C);
	assign st.heap_empty = (count_q == '0);
	assign st.up_done = (idx_q == '0);
	assign st.dn_done = !l_in;
	assign st.last = last_q;
	assign st.push = push_q;

	assign f_we = cmd.do_push;
	assign l_we = cmd.do_push;
	assign f_ra = fhead_q;
	assign l_ra = AW'(count_q - 1'b1);

	logic [AW-1:0] par;
	assign par = AW'((idx_q - 1'b1) >> 1);

	// heap port a reads root/parent/child1, port b last entry/child2
	always_comb begin
		h_ra = '0;
		h_ra2 = '0;
		if (cmd.pop_rd) begin
			h_ra = '0;
			h_ra2 = AW'(count_q - 1'b1);
		end else if (cmd.up_rd) begin
			h_ra = par;
		end else if (cmd.dn_rd) begin
			h_ra = AW'(l_full);
			h_ra2 = r_in ? AW'(r_full) : AW'(l_full);
		end
	end

	logic signed [VALUE_WIDTH-1:0] big_v;
	logic [AW-1:0] big_i;
	logic go_l, go_r;
	always_comb begin
		go_r = rd_kid_q && (h_rd2 > h_rd);
		big_v = go_r ? h_rd2 : h_rd;
		big_i = go_r ? AW'(chl_q + 1'b1) : chl_q;
		go_l = big_v > cur_q;
	end

	always_comb begin
		h_we = 1'b0;
		h_wa = idx_q;
		h_wd = cur_q;
		h2_we = 1'b0;
		h2_wa = idx_q;
		h2_wd = cur_q;
		if (cmd.do_push) begin
			h_we = 1'b1;
			h_wa = AW'(count_q);
			h_wd = val_q;
		end else if (cmd.pop_last) begin
			h_we = 1'b1;
			h_wa = '0;
			h_wd = cur_q;
		end else if (cmd.up_cmp && (h_rd < cur_q)) begin
			h_we = 1'b1;
			h_wa = idx_q;
			h_wd = cur_q;
			h2_we = 1'b1;
			h2_wa = chl_q;
			h2_wd = h_rd;
		end else if (cmd.dn_cmp && go_l) begin
			h_we = 1'b1;
			h_wa = big_i;
			h_wd = cur_q;
			h2_we = 1'b1;
			h2_wa = idx_q;
			h2_wd = big_v;
		end
	end

	// two heap copies keep one write port each; same contents
	logic [AW-1:0] ha_waddr, hb_waddr;
	logic signed [VALUE_WIDTH-1:0] ha_wdata;
	logic ha_we;
	logic [AW-1:0] pend_a_q;
	logic signed [VALUE_WIDTH-1:0] pend_d_q;
	logic pend_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= 1'b0;
		else pend_q <= h2_we;
	end
	always_ff @(posedge clk) begin
		pend_a_q <= h2_wa;
		pend_d_q <= h2_wd;
	end
	assign ha_we = h_we || pend_q;
	assign ha_waddr = h_we ? h_wa : pend_a_q;
	assign ha_wdata = h_we ? h_wd : pend_d_q;
	assign hb_waddr = ha_waddr;

	ppoc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_fifo (
		.clk, .we(f_we), .waddr(f_wa), .wdata(val_q), .raddr(f_ra), .rdata(f_rd));
	ppoc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_lifo (
		.clk, .we(l_we), .waddr(l_wa), .wdata(val_q), .raddr(l_ra), .rdata(l_rd));
	ppoc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_heap_a (
		.clk, .we(ha_we), .waddr(ha_waddr), .wdata(ha_wdata), .raddr(h_ra), .rdata(h_rd));
	ppoc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_heap_b (
		.clk, .we(ha_we), .waddr(hb_waddr), .wdata(ha_wdata), .raddr(h_ra2), .rdata(h_rd2));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= vn;
			push_q <= opcode;
			last_q <= end_of_trace;
		end
		if (cmd.do_push) begin
			idx_q <= AW'(count_q);
			chl_q <= AW'(count_q);
			cur_q <= val_q;
		end
		if (cmd.pop_cmp) begin
			cur_q <= h_rd2;
			idx_q <= '0;
		end
		if (cmd.up_rd) begin
			chl_q <= idx_q;
			idx_q <= par;
		end
		if (cmd.up_cmp && !(h_rd < cur_q)) begin
			idx_q <= '0;
		end
		if (cmd.dn_rd) begin
			chl_q <= AW'(l_full);
			rd_kid_q <= r_in;
		end
		if (cmd.dn_cmp) begin
			if (go_l) idx_q <= big_i;
			else idx_q <= {AW{1'b1}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fhead_q <= '0;
			count_q <= '0;
			flags_q <= '1;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.load && opcode && (count_q >= DEPTH_C)) ovf_q <= 1'b1;
			if (cmd.do_push) count_q <= count_q + 1'b1;
			if (cmd.pop_cmp) begin
				if (st.heap_empty || f_rd != val_q) flags_q[FLAG_QUEUE_BIT] <= 1'b0;
				if (st.heap_empty || l_rd != val_q) flags_q[FLAG_STACK_BIT] <= 1'b0;
				if (st.heap_empty || h_rd != val_q) flags_q[FLAG_PRIO_BIT] <= 1'b0;
				if (!st.heap_empty) begin
					count_q <= count_q - 1'b1;
					fhead_q <= (fhead_q == AW'(DEPTH - 1)) ? '0 : fhead_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				fhead_q <= '0;
				count_q <= '0;
				flags_q <= '1;
				ovf_q <= 1'b0;
			end
		end
	end

	logic [1:0] nsel;
	assign nsel = 2'(flags_q[0]) + 2'(flags_q[1]) + 2'(flags_q[2]);
	always_comb begin
		if (nsel > 2'd1) verdict = VERDICT_UNSURE;
		else if (flags_q[FLAG_STACK_BIT]) verdict = VERDICT_STACK;
		else if (flags_q[FLAG_QUEUE_BIT]) verdict = VERDICT_QUEUE;
		else if (flags_q[FLAG_PRIO_BIT]) verdict = VERDICT_PRIO;
		else verdict = VERDICT_NONE;
	end
	assign overflowed = ovf_q;
endmodule

>>> hdl/push_pop_order_classifier_top.sv
// push: load, write, sift up; pop: load, read, compare, last to root, sift down
// input: one item at a time, s_tready stays low until the last item is done
// the heap sift loop through its memory read and swap write sets the time per item
// reset: arst_n clears the controller, counters, flags and output valid flag at once
// store contents need no clearing since only entries written in the trace are read
module push_pop_order_classifier_top
	import ppoc_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata, // opcode, value
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata // verdict, overflowed
);
	cmd_t cmd;
	status_t st;
	logic busy, in_fire;
	logic [2:0] verdict;
	logic overflowed;
	logic [3:0] out_q;
	logic out_v_q;

	assign s_tready = !busy;
	assign in_fire = s_tvalid && s_tready;

	ppoc_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .out_free(!out_v_q || m_tready), .st, .cmd, .busy);

	ppoc_dp #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk, .arst_n, .cmd, .opcode(s_tdata[0]), .value(s_tdata[32:1]),
		.end_of_trace(s_tlast), .st, .verdict, .overflowed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.finish) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.finish) out_q <= {overflowed, verdict};
	end
	assign m_tvalid = out_v_q;
	assign m_tdata = {4'd0, out_q};

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready) else $error("accept while busy");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> m_tvalid) else $error("lost result");
	a_verd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= VERDICT_NONE) else $error("bad verdict");
endmodule
